// File: rtl/core/brb_pkg.sv
`default_nettype none

package brb_pkg;

  localparam int STORE_DEPTH    = 256;
  localparam int READ_MAX_BYTES = 64;

  localparam int LEN_CAP = (STORE_DEPTH < 256) ? STORE_DEPTH : 256;
  localparam int POS_W   = $clog2(LEN_CAP);
  localparam int LEN_W   = POS_W + 1;
  localparam int CFG_W   = 9;
  localparam int XFER_W  = 11;
  localparam int LEFT_W  = $clog2(READ_MAX_BYTES + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef enum logic [2:0] {
    CMD_WRITE  = 3'd0,
    CMD_READ   = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_SKIP   = 3'd3,
    CMD_REVERT = 3'd4
  } command_t;

  localparam logic REG_BUFFER_LENGTH   = 1'b0;
  localparam logic REG_ENTRY_SIZE_LOG2 = 1'b1;

  typedef enum logic {
    FS_IDLE,
    FS_STREAM
  } front_state_t;

  typedef struct packed {
    logic       mem_wr;
    logic       mem_rd;
    pos_t       addr;
    logic [7:0] data;
    logic [7:0] done;
    logic       last;
    logic [7:0] used;
    logic [7:0] free;
    logic       is_empty;
    logic       is_full;
  } op_t;

  // a < n, b < n
  function automatic pos_t wrap_add(pos_t a, len_t b, len_t n);
    len_t s;
    s = len_t'(a) + b;
    if (s >= n) s = s - n;
    return pos_t'(s);
  endfunction

  function automatic pos_t wrap_sub(pos_t a, len_t b, len_t n);
    len_t s;
    if (len_t'(a) >= b) s = len_t'(a) - b;
    else s = len_t'(a) + n - b;
    return pos_t'(s);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/byte_ring_buffer_peek_skip_revert.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------------
// input    | push / full        | command, data_byte, burst_last, burst_bytes,
//          |                    | entry_count, peek_offset
// result   | pop / empty        | out_byte, byte_valid, entries_done, last,
//          |                    | used_bytes, free_bytes, is_empty, is_full
// config   | cfg_write          | cfg_index, cfg_data
//
// Write, peek, skip, revert and unknown items give one result each.
// A read of N bytes holds full while the front issues its remaining bytes,
// one per cycle while the op queue is not full.
// A result passes through the op queue and the result register to the ports.
// Synchronous reset clears positions, burst state, queue and result valid flag;
// the byte store is not cleared. full also rises while the 4-entry queue is full.
`default_nettype none

module byte_ring_buffer_peek_skip_revert (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic                      cfg_index,
  input  wire logic [brb_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [2:0]                command,
  input  wire logic [7:0]                data_byte,
  input  wire logic                      burst_last,
  input  wire logic [7:0]                burst_bytes,
  input  wire logic [7:0]                entry_count,
  input  wire logic [7:0]                peek_offset,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [7:0]                     out_byte,
  output logic                           byte_valid,
  output logic [7:0]                     entries_done,
  output logic                           last,
  output logic [7:0]                     used_bytes,
  output logic [7:0]                     free_bytes,
  output logic                           is_empty,
  output logic                           is_full
);
  import brb_pkg::*;

  op_t  f_op;
  op_t  b_op;
  logic f_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  brb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .command     (command),
    .data_byte   (data_byte),
    .burst_last  (burst_last),
    .burst_bytes (burst_bytes),
    .entry_count (entry_count),
    .peek_offset (peek_offset),
    .q_push      (f_push),
    .q_op        (f_op),
    .q_full      (q_full)
  );

  brb_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (f_push),
    .op_in  (f_op),
    .full   (q_full),
    .pop    (q_pop),
    .op_out (b_op),
    .empty  (q_empty)
  );

  brb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_op         (b_op),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .entries_done (entries_done),
    .last         (last),
    .used_bytes   (used_bytes),
    .free_bytes   (free_bytes),
    .is_empty     (is_empty),
    .is_full      (is_full)
  );

endmodule

`default_nettype wire

// File: rtl/core/brb_front.sv
`default_nettype none

module brb_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic                       cfg_index,
  input  wire logic [brb_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [2:0]                 command,
  input  wire logic [7:0]                 data_byte,
  input  wire logic                       burst_last,
  input  wire logic [7:0]                 burst_bytes,
  input  wire logic [7:0]                 entry_count,
  input  wire logic [7:0]                 peek_offset,
  output logic                            q_push,
  output brb_pkg::op_t                    q_op,
  input  wire logic                       q_full
);
  import brb_pkg::*;

  front_state_t      state, state_next;
  pos_t              rp, rp_next;
  pos_t              wp, wp_next;
  logic              burst_open, burst_open_next;
  logic              burst_accepted, burst_accepted_next;
  logic [7:0]        burst_total, burst_total_next;
  logic [7:0]        burst_count, burst_count_next;
  logic [CFG_W-1:0]  buf_len;
  logic [1:0]        esl;
  op_t               stream_op, stream_op_next;
  pos_t              stream_addr, stream_addr_next;
  logic [LEFT_W-1:0] stream_left, stream_left_next;

  len_t              n;
  pos_t              used;
  pos_t              used_n;
  pos_t              free;
  logic [XFER_W-1:0] bytes;
  logic [XFER_W-1:0] eff_bytes;
  logic              accept;
  logic              acc_c;
  logic [7:0]        tot_c;
  logic [7:0]        cnt_c;
  logic [7:0]        cnt_n;
  logic              store;
  op_t               op;

  always_comb begin
    if (buf_len < CFG_W'(2)) n = len_t'(2);
    else if (buf_len > CFG_W'(LEN_CAP)) n = len_t'(LEN_CAP);
    else n = len_t'(buf_len);
  end

  assign used  = wrap_sub(wp, len_t'(rp), n);
  assign free  = pos_t'(n - len_t'(1) - len_t'(used));
  assign bytes = XFER_W'(entry_count) << esl;

  assign full   = (state != FS_IDLE) || q_full;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_len <= CFG_W'(256);
      esl     <= 2'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BUFFER_LENGTH:   buf_len <= cfg_data;
        REG_ENTRY_SIZE_LOG2: esl     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= FS_IDLE;
      rp             <= '0;
      wp             <= '0;
      burst_open     <= 1'b0;
      burst_accepted <= 1'b0;
      burst_total    <= '0;
      burst_count    <= '0;
    end else begin
      state          <= state_next;
      rp             <= rp_next;
      wp             <= wp_next;
      burst_open     <= burst_open_next;
      burst_accepted <= burst_accepted_next;
      burst_total    <= burst_total_next;
      burst_count    <= burst_count_next;
    end
  end

  always_ff @(posedge clk) begin
    stream_op   <= stream_op_next;
    stream_addr <= stream_addr_next;
    stream_left <= stream_left_next;
  end

  always_comb begin
    state_next          = state;
    rp_next             = rp;
    wp_next             = wp;
    burst_open_next     = burst_open;
    burst_accepted_next = burst_accepted;
    burst_total_next    = burst_total;
    burst_count_next    = burst_count;
    stream_op_next      = stream_op;
    stream_addr_next    = stream_addr;
    stream_left_next    = stream_left;
    used_n              = used;
    eff_bytes           = '0;
    acc_c               = burst_accepted;
    tot_c               = burst_total;
    cnt_c               = burst_count;
    cnt_n               = burst_count;
    store               = 1'b0;
    op                  = '0;
    q_push              = 1'b0;
    q_op                = '0;

    unique case (state)
      FS_IDLE: begin
        if (accept) begin
          q_push  = 1'b1;
          op.last = 1'b1;
          case (command_t'(command))
            CMD_WRITE: begin
              if (!burst_open) begin
                acc_c = (burst_bytes != 8'd0) && (9'(burst_bytes) <= 9'(free));
                tot_c = burst_bytes;
                cnt_c = 8'd0;
              end
              store     = acc_c && (cnt_c < tot_c);
              cnt_n     = cnt_c + 8'(store);
              op.mem_wr = store;
              op.addr   = wp;
              op.data   = data_byte;
              if (store) begin
                wp_next = wrap_add(wp, len_t'(1), n);
                used_n  = used + pos_t'(1);
              end
              burst_total_next = tot_c;
              if (burst_last) begin
                op.done             = acc_c ? (cnt_n >> esl) : 8'd0;
                burst_open_next     = 1'b0;
                burst_accepted_next = 1'b0;
                burst_count_next    = 8'd0;
              end else begin
                burst_open_next     = 1'b1;
                burst_accepted_next = acc_c;
                burst_count_next    = cnt_n;
              end
            end
            CMD_READ: begin
              if (bytes != '0 && bytes <= XFER_W'(READ_MAX_BYTES) &&
                  bytes <= XFER_W'(used)) begin
                rp_next   = wrap_add(rp, len_t'(bytes), n);
                used_n    = used - pos_t'(bytes);
                op.mem_rd = 1'b1;
                op.addr   = rp;
                op.done   = entry_count;
                op.last   = (bytes == XFER_W'(1));
                if (bytes != XFER_W'(1)) begin
                  state_next       = FS_STREAM;
                  stream_addr_next = wrap_add(rp, len_t'(1), n);
                  stream_left_next = LEFT_W'(bytes - XFER_W'(1));
                end
              end
            end
            CMD_PEEK: begin
              if (9'(peek_offset) < 9'(used)) begin
                op.mem_rd = 1'b1;
                op.addr   = wrap_add(rp, len_t'(peek_offset), n);
              end
            end
            CMD_SKIP: begin
              if (bytes > XFER_W'(used)) begin
                eff_bytes = XFER_W'(used);
                rp_next   = wp;
                used_n    = '0;
              end else begin
                eff_bytes = bytes;
                rp_next   = wrap_add(rp, len_t'(bytes), n);
                used_n    = used - pos_t'(bytes);
              end
              op.done = 8'(eff_bytes >> esl);
            end
            CMD_REVERT: begin
              if (bytes > XFER_W'(used)) begin
                eff_bytes = XFER_W'(used);
                wp_next   = rp;
                used_n    = '0;
              end else begin
                eff_bytes = bytes;
                wp_next   = wrap_sub(wp, len_t'(bytes), n);
                used_n    = used - pos_t'(bytes);
              end
              op.done = 8'(eff_bytes >> esl);
            end
            default: ;
          endcase
          op.used     = 8'(used_n);
          op.free     = 8'(n - len_t'(1) - len_t'(used_n));
          op.is_empty = (used_n == '0);
          op.is_full  = (len_t'(used_n) == n - len_t'(1));
          q_op           = op;
          stream_op_next = op;
        end
      end
      FS_STREAM: begin
        if (!q_full) begin
          q_push           = 1'b1;
          q_op             = stream_op;
          q_op.addr        = stream_addr;
          q_op.last        = (stream_left == LEFT_W'(1));
          stream_addr_next = wrap_add(stream_addr, len_t'(1), n);
          stream_left_next = stream_left - LEFT_W'(1);
          if (stream_left == LEFT_W'(1)) state_next = FS_IDLE;
        end
      end
      default: state_next = FS_IDLE;
    endcase

    // new length empties the buffer
    if (cfg_write && cfg_index == REG_BUFFER_LENGTH) begin
      rp_next             = '0;
      wp_next             = '0;
      burst_open_next     = 1'b0;
      burst_accepted_next = 1'b0;
      burst_total_next    = 8'd0;
      burst_count_next    = 8'd0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/brb_queue.sv
`default_nettype none

module brb_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire brb_pkg::op_t op_in,
  output logic              full,
  input  wire logic         pop,
  output brb_pkg::op_t      op_out,
  output logic              empty
);
  import brb_pkg::*;

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign op_out  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= op_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/brb_back.sv
`default_nettype none

module brb_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire brb_pkg::op_t q_op,
  input  wire logic         q_empty,
  output logic              q_pop,
  input  wire logic         pop,
  output logic              empty,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic [7:0]        entries_done,
  output logic              last,
  output logic [7:0]        used_bytes,
  output logic [7:0]        free_bytes,
  output logic              is_empty,
  output logic              is_full
);
  import brb_pkg::*;

  logic [7:0] mem [LEN_CAP];
  logic [7:0] rdata;
  op_t        res;
  logic       res_valid;

  assign q_pop = !q_empty && (!res_valid || pop);

  always_ff @(posedge clk) begin
    if (q_pop && q_op.mem_wr) mem[q_op.addr] <= q_op.data;
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_op.mem_rd) rdata <= mem[q_op.addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop) res <= q_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  assign empty        = !res_valid;
  assign out_byte     = res.mem_rd ? rdata : 8'd0;
  assign byte_valid   = res.mem_rd;
  assign entries_done = res.done;
  assign last         = res.last;
  assign used_bytes   = res.used;
  assign free_bytes   = res.free;
  assign is_empty     = res.is_empty;
  assign is_full      = res.is_full;

endmodule

`default_nettype wire

// File: rtl/core/brb_checker.sv
`default_nettype none

module brb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       byte_valid,
  input wire logic       last,
  input wire logic [7:0] used_bytes,
  input wire logic [7:0] free_bytes,
  input wire logic       is_empty,
  input wire logic       is_full
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    !empty && is_empty |-> used_bytes == 8'd0)
    else $error("is_empty with bytes held");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    !empty && is_full |-> free_bytes == 8'd0 && !is_empty)
    else $error("is_full with free space");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    !empty && !byte_valid |-> last)
    else $error("status result not marked last");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("stalled result dropped");

endmodule

bind byte_ring_buffer_peek_skip_revert brb_checker u_checker (.*);

`default_nettype wire
